### sv/iad_pkg.sv
// Shared types and constants for the integer to ASCII digit emitter.
`timescale 1ns / 1ps
package iad_pkg;

  // Format selector codes on the input beat
  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;

  localparam logic [7:0] MINUS_CHAR = 8'h2d;

  // Digit characters; index 0 holds '0'
  localparam logic [15:0][7:0] HEX_CHARS = "fedcba9876543210";

  // Double dabble: 32 bits, two per cycle
  localparam int DEC_BITS       = 32;
  localparam int BITS_PER_CYCLE = 2;
  localparam int CONV_CYCLES    = DEC_BITS / BITS_PER_CYCLE;
  localparam logic [3:0] CONV_LAST = 4'(CONV_CYCLES - 1);

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic        clear_total;
  } in_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        last_char;
    logic [31:0] running_total;
  } out_t;

  typedef enum logic [1:0] {
    MODE_DEC,
    MODE_HEX,
    MODE_NONE
  } mode_t;

  // Classified job passed from front to back
  typedef struct packed {
    mode_t       mode;
    logic        neg;
    logic        clear;
    logic [63:0] mag;
  } job_t;

endpackage

### sv/iad_front.sv
// Front end: accepts input beats and classifies them into conversion jobs.
`timescale 1ns / 1ps
module iad_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  iad_pkg::in_t  in_data,
  output logic          push_valid,
  input  logic          push_ready,
  output iad_pkg::job_t push_job
);
  import iad_pkg::*;

  logic [31:0] low;

  assign low        = in_data.value[31:0];
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_job.clear = in_data.clear_total;
    push_job.neg   = 1'b0;
    push_job.mag   = {32'd0, low};
    case (in_data.op)
      OP_SDEC: begin
        push_job.mode = MODE_DEC;
        if (low[31]) begin
          push_job.neg = 1'b1;
          // most negative value negates to itself, which is the right magnitude
          push_job.mag = {32'd0, 32'd0 - low};
        end
      end
      OP_UDEC: push_job.mode = MODE_DEC;
      OP_HEX: begin
        push_job.mode = MODE_HEX;
        push_job.mag  = in_data.value;
      end
      default: push_job.mode = MODE_NONE;
    endcase
  end

endmodule

### sv/iad_queue.sv
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module iad_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  iad_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output iad_pkg::job_t pop_job
);
  import iad_pkg::*;

  job_t       entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) entries_r[wr_ptr_r] <= push_job;
  end

endmodule

### sv/iad_back.sv
// Back end: decimal conversion, digit emission and the running total.
`timescale 1ns / 1ps
module iad_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  iad_pkg::job_t pop_job,
  output logic          out_valid,
  input  logic          out_ready,
  output iad_pkg::out_t out_data
);
  import iad_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] buf_r, buf_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] bin_r, bin_nxt;
  logic [39:0] bcd_r, bcd_nxt;
  logic [31:0] total_r, total_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;
  logic [71:0] dd;
  logic [3:0]  digit;

  // one shift-add-3 step over {bcd, bin}
  function automatic logic [71:0] dd_step(input logic [71:0] sr);
    logic [71:0] t;
    t = sr;
    for (int i = 0; i < 10; i++) begin
      if (t[32 + 4*i +: 4] >= 4'd5) t[32 + 4*i +: 4] = t[32 + 4*i +: 4] + 4'd3;
    end
    return {t[70:0], 1'b0};
  endfunction

  // position of the most significant nonzero nibble, 0 for zero
  function automatic logic [3:0] msd(input logic [63:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[4*i +: 4] != 4'd0) r = 4'(i);
    end
    return r;
  endfunction

  assign pop_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign dd        = dd_step(dd_step({bcd_r, bin_r}));
  assign digit     = buf_r[{idx_r, 2'b00} +: 4];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    buf_nxt       = buf_r;
    idx_nxt       = idx_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          if (pop_job.clear) total_nxt = 32'd0;
          neg_nxt = pop_job.neg;
          buf_nxt = pop_job.mag;
          idx_nxt = msd(pop_job.mag);
          bin_nxt = pop_job.mag[31:0];
          bcd_nxt = 40'd0;
          cnt_nxt = 4'd0;
          case (pop_job.mode)
            MODE_DEC:  state_nxt = ST_CONV;
            MODE_HEX:  state_nxt = ST_EMIT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        bcd_nxt = dd[71:32];
        bin_nxt = dd[31:0];
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == CONV_LAST) begin
          buf_nxt   = {24'd0, dd[71:32]};
          idx_nxt   = msd({24'd0, dd[71:32]});
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          total_nxt                  = total_r + 32'd1;
          out_data_nxt.running_total = total_r + 32'd1;
          if (neg_r) begin
            neg_nxt                = 1'b0;
            out_data_nxt.char_code = MINUS_CHAR;
            out_data_nxt.last_char = 1'b0;
          end else begin
            out_data_nxt.char_code = HEX_CHARS[digit];
            out_data_nxt.last_char = (idx_r == 4'd0);
            if (idx_r == 4'd0) state_nxt = ST_IDLE;
            else idx_nxt = idx_r - 4'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= 32'd0;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      cnt_r       <= 4'd0;
      idx_r       <= 4'd0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
    end
    buf_r      <= buf_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### sv/integer_to_ascii_digits_top.sv
// Top level of the integer to ASCII digit emitter.
`timescale 1ns / 1ps
// Converts one number per input beat into ASCII characters, most significant
// first, one output beat per character with last_char on the final one. op 0
// prints the low 32 bits as signed decimal, op 1 as unsigned decimal, op 2
// prints all 64 bits as lowercase hex; op 3 prints nothing but still honors
// clear_total. A two-entry queue lets new numbers be taken while the back end
// works. The back end handles one number at a time: it takes the job, then for
// decimal runs the two-bit-per-cycle double dabble converter, then emits one
// character per cycle (up to 11 decimal, 16 hex) at the registered output,
// unless the receiver holds off out_ready.
module integer_to_ascii_digits_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  iad_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output iad_pkg::out_t out_data
);
  import iad_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  job_t push_job, pop_job;

  iad_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  iad_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  iad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/iad_digit_checker.sv
// Checker for the integer to ASCII digit emitter: predicts each character beat and compares.
`timescale 1ns / 1ps
module iad_digit_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  iad_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  iad_pkg::out_t out_data,
  output int            results_pending,
  output int            mismatch_count
);
  import iad_pkg::*;

  localparam logic [7:0] ZERO_CHAR  = "0";
  localparam logic [7:0] ALPHA_BASE = "a";
  localparam logic [7:0] DASH_CHAR  = "-";

  out_t        expected_chars[$];
  logic [31:0] emitted_count;

  initial begin
    results_pending = 0;
    mismatch_count  = 0;
    emitted_count   = '0;
  end

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return ZERO_CHAR + 8'(nib);
    end
    return ALPHA_BASE + 8'(nib - 4'd10);
  endfunction

  // Queues one expected beat per character of the accepted number
  task automatic predict_digits(input in_t item);
    logic [7:0]  text[$];
    logic [31:0] mag;
    logic [63:0] hv;
    logic        neg;
    out_t        beat;
    int          k;
    neg = 1'b0;
    if (item.clear_total) begin
      emitted_count = '0;
    end
    case (item.op)
      OP_SDEC, OP_UDEC: begin
        mag = item.value[31:0];
        if (item.op == OP_SDEC && mag[31]) begin
          neg = 1'b1;
          mag = 32'd0 - mag;  // most negative value maps onto itself, read unsigned
        end
        do begin
          text.push_front(ZERO_CHAR + 8'(mag % 32'd10));
          mag = mag / 32'd10;
        end while (mag != 32'd0);
        if (neg) begin
          text.push_front(DASH_CHAR);
        end
      end
      OP_HEX: begin
        hv = item.value;
        do begin
          text.push_front(nibble_char(hv[3:0]));
          hv = hv >> 4;
        end while (hv != 64'd0);
      end
      default: begin
      end
    endcase
    for (k = 0; k < text.size(); k++) begin
      emitted_count        = emitted_count + 32'd1;
      beat.char_code       = text[k];
      beat.last_char       = (k == text.size() - 1);
      beat.running_total   = emitted_count;
      expected_chars.push_back(beat);
    end
  endtask

  task automatic compare_char(input out_t got);
    out_t want;
    if (expected_chars.size() == 0) begin
      $error("unexpected beat: char_code %0h last_char %0b running_total %0d",
             got.char_code, got.last_char, got.running_total);
      mismatch_count++;
      return;
    end
    want = expected_chars.pop_front();
    if (got.char_code !== want.char_code) begin
      $error("char_code expected %0h actual %0h", want.char_code, got.char_code);
      mismatch_count++;
    end
    if (got.last_char !== want.last_char) begin
      $error("last_char expected %0b actual %0b", want.last_char, got.last_char);
      mismatch_count++;
    end
    if (got.running_total !== want.running_total) begin
      $error("running_total expected %0d actual %0d", want.running_total,
             got.running_total);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_chars.delete();
      emitted_count = '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_digits(in_data);
      end
      if (out_valid && out_ready) begin
        compare_char(out_data);
      end
    end
    results_pending <= expected_chars.size();
  end

endmodule

### tb/integer_to_ascii_digits_top_tb.sv
// Testbench top for the integer to ASCII digit emitter: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module integer_to_ascii_digits_top_tb;
  import iad_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 18;
  localparam int         LONG_HOLD   = 250;
  localparam int         TAIL_CYCLES = 60;
  localparam int         CYCLE_LIMIT = 500000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic idle_on      = 1'b1;
  logic hold_request = 1'b0;
  int   results_pending;
  int   mismatch_count;
  int   cycle_count  = 0;

  integer_to_ascii_digits_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  iad_digit_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .results_pending (results_pending),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random back-pressure, plus one long hold-off on request
  initial begin
    int stall_left;
    int roll;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!idle_on) begin
        out_ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready  <= 1'b0;
          stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
    end
  end

  function automatic in_t make_item(input logic [1:0] op, input logic [63:0] value,
                                    input logic clear);
    in_t item;
    item.op          = op;
    item.value       = value;
    item.clear_total = clear;
    return item;
  endfunction

  function automatic in_t random_number();
    in_t         item;
    int          roll;
    logic [63:0] p;
    roll = $urandom_range(0, 99);
    if (roll < 31) item.op = OP_SDEC;
    else if (roll < 62) item.op = OP_UDEC;
    else if (roll < 92) item.op = OP_HEX;
    else item.op = OP_UNUSED;
    case ($urandom_range(0, 4))
      0: item.value = {$urandom, $urandom};
      1: item.value = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: item.value = {$urandom, 32'($urandom_range(0, 20))};
      3: begin
        // decimal digit-count boundaries, junk in the upper half (ignored by decimal ops)
        p = 64'd1;
        repeat ($urandom_range(0, 9)) p = p * 64'd10;
        item.value = {$urandom, 32'(p - 64'($urandom_range(0, 1)))};
      end
      default: item.value = 64'hFFFF_FFFF_FFFF_FFFF >> $urandom_range(0, 63);
    endcase
    item.clear_total = ($urandom_range(0, 9) == 0);
    return item;
  endfunction

  // Holds the beat until accepted, then maybe idles
  task automatic send_number(input in_t item);
    int gap;
    int roll;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    if (idle_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 92) gap = $urandom_range(10, 30);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    in_t item;
    int  counted;
    counted = 0;
    while (counted < count) begin
      item = random_number();
      send_number(item);
      if (item.op != OP_UNUSED) counted++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_number(make_item(OP_SDEC, 64'd0, 1'b1));
    send_number(make_item(OP_SDEC, 64'd1, 1'b0));
    send_number(make_item(OP_SDEC, 64'h0000_0000_FFFF_FFFF, 1'b0));
    send_number(make_item(OP_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b0));
    send_number(make_item(OP_SDEC, 64'h0000_0000_8000_0000, 1'b0));
    send_number(make_item(OP_SDEC, 64'h0000_0000_8000_0001, 1'b0));
    send_number(make_item(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFF6, 1'b0));
    send_number(make_item(OP_SDEC, 64'hDEAD_BEEF_0000_007B, 1'b0));
    send_number(make_item(OP_UDEC, 64'd0, 1'b0));
    send_number(make_item(OP_UDEC, 64'd9, 1'b0));
    send_number(make_item(OP_UDEC, 64'd10, 1'b0));
    send_number(make_item(OP_UDEC, 64'h0000_0000_FFFF_FFFF, 1'b0));
    send_number(make_item(OP_UDEC, 64'hFFFF_FFFF_8000_0000, 1'b0));
    send_number(make_item(OP_UDEC, 64'd1000000000, 1'b0));
    send_number(make_item(OP_HEX, 64'd0, 1'b0));
    send_number(make_item(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
    send_number(make_item(OP_HEX, 64'h8000_0000_0000_0000, 1'b0));
    send_number(make_item(OP_HEX, 64'h0123_4567_89AB_CDEF, 1'b0));
    send_number(make_item(OP_HEX, 64'hFEDC_BA98_7654_3210, 1'b0));
    // unused selector: no beats out, but the clear still lands
    send_number(make_item(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
    send_number(make_item(OP_UNUSED, 64'd0, 1'b0));
    send_number(make_item(OP_HEX, 64'd16, 1'b1));

    send_random(RANDOM_ITEMS);

    // long receiver hold-off while numbers keep coming back to back
    idle_on      <= 1'b0;
    hold_request <= 1'b1;
    send_random(RANDOM_ITEMS);
    wait_drained();

    send_random(RANDOM_ITEMS);
    idle_on <= 1'b1;
    send_random(RANDOM_ITEMS);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
